/* sv/lcs_pkg.sv */
// Shared types, register codes and reset values of the load current supervisor.
`timescale 1ns / 1ps

package lcs_pkg;

  localparam int unsigned DacW = 12;
  localparam int unsigned TempW = 12;
  localparam int unsigned SetpW = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned HystW = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ProdW = SetpW + GainW + 2;

  localparam logic [DacW-1:0] DacMax = 12'd4095;

  localparam logic signed [TempW-1:0] TempLimitRst = 12'sd800;
  localparam logic signed [TempW-1:0] FanOnTempRst = 12'sd450;
  localparam logic [HystW-1:0] FanHystRst = 8'd50;
  localparam logic [GainW-1:0] DacGainRst = 16'd209;

  typedef enum logic [1:0] {
    OP_REGULATE = 2'd0,
    OP_SWITCH_ON = 2'd1,
    OP_SWITCH_OFF = 2'd2
  } lcs_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_LIMIT = 2'd0,
    REG_FAN_ON_TEMP = 2'd1,
    REG_FAN_BAND = 2'd2,
    REG_DAC_GAIN = 2'd3
  } lcs_reg_e;

  typedef struct packed {
    logic signed [TempW-1:0] temp_limit;
    logic signed [TempW-1:0] fan_on_temp;
    logic [HystW-1:0] fan_band;
    logic [GainW-1:0] dac_gain;
  } lcs_cfg_t;

  typedef struct packed {
    logic [1:0] op;
    logic signed [SetpW-1:0] setpoint;
    logic signed [TempW-1:0] temp;
  } lcs_item_t;

  typedef struct packed {
    logic enabled;
    logic fault;
    logic fan;
    logic dac_en;
    logic [DacW-1:0] dac_value;
  } lcs_state_t;

endpackage

/* sv/lcs_cfg_regs.sv */
// Configuration register file of the load current supervisor.
`timescale 1ns / 1ps

module lcs_cfg_regs import lcs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                cfg_ready_o,
  output lcs_cfg_t            cfg_o
);

  lcs_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (lcs_reg_e'(cfg_index_i))
        REG_TEMP_LIMIT:  cfg_d.temp_limit = $signed(cfg_data_i[TempW-1:0]);
        REG_FAN_ON_TEMP: cfg_d.fan_on_temp = $signed(cfg_data_i[TempW-1:0]);
        REG_FAN_BAND:    cfg_d.fan_band = cfg_data_i[HystW-1:0];
        REG_DAC_GAIN:    cfg_d.dac_gain = cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_limit <= TempLimitRst;
      cfg_q.fan_on_temp <= FanOnTempRst;
      cfg_q.fan_band <= FanHystRst;
      cfg_q.dac_gain <= DacGainRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/lcs_step.sv */
// Next-state logic for one command: scaling, saturation, fault and fan updates.
`timescale 1ns / 1ps

module lcs_step import lcs_pkg::*; (
  input  lcs_cfg_t   cfg_i,
  input  lcs_item_t  item_i,
  input  lcs_state_t state_i,
  output lcs_state_t state_o
);

  logic signed [ProdW-1:0] prod;
  logic                    pos_sat;
  logic                    neg_sat;
  logic                    sat;
  logic [DacW-1:0]         scaled;
  logic signed [TempW:0]   temp_x;
  logic signed [TempW:0]   fan_off_thr;
  logic                    over_temp;
  logic                    fan_hot;
  logic                    fan_cool;
  logic                    fault_r;
  logic                    fan_r;

  assign prod = $signed({item_i.setpoint[SetpW-1], item_i.setpoint}) *
                $signed({1'b0, cfg_i.dac_gain});

  assign neg_sat = (prod < -$signed(ProdW'(255)));
  assign pos_sat = !prod[ProdW-1] && (prod[ProdW-2:DacW+8] != '0);
  assign sat = neg_sat | pos_sat;

  always_comb begin
    if (pos_sat) begin
      scaled = DacMax;
    end else if (prod[ProdW-1]) begin
      scaled = '0;
    end else begin
      scaled = prod[DacW+7:8];
    end
  end

  assign temp_x = {item_i.temp[TempW-1], item_i.temp};
  assign fan_off_thr = $signed({cfg_i.fan_on_temp[TempW-1], cfg_i.fan_on_temp}) -
                       $signed({{(TempW+1-HystW){1'b0}}, cfg_i.fan_band});
  assign over_temp = (item_i.temp >= cfg_i.temp_limit);
  assign fan_hot = (item_i.temp >= cfg_i.fan_on_temp);
  assign fan_cool = (temp_x < fan_off_thr);

  assign fault_r = state_i.fault | (state_i.enabled & over_temp);
  assign fan_r = (state_i.fan | (state_i.enabled & fan_hot)) & !fan_cool;

  always_comb begin
    state_o = state_i;
    unique case (lcs_op_e'(item_i.op))
      OP_REGULATE: begin
        state_o.fault = fault_r;
        state_o.fan = fan_r;
        if (state_i.enabled) begin
          if (fault_r) begin
            state_o.enabled = 1'b0;
            state_o.dac_en = 1'b0;
            state_o.dac_value = '0;
          end else if (sat) begin
            state_o.fault = 1'b1;
            state_o.enabled = 1'b0;
            state_o.dac_en = 1'b0;
            state_o.dac_value = '0;
          end else begin
            state_o.dac_value = scaled;
          end
        end
      end
      OP_SWITCH_ON: begin
        state_o.enabled = 1'b1;
        state_o.fault = sat;
        state_o.dac_value = scaled;
        state_o.dac_en = 1'b1;
      end
      OP_SWITCH_OFF: begin
        state_o.enabled = 1'b0;
        state_o.dac_en = 1'b0;
        state_o.dac_value = '0;
      end
      default: ;
    endcase
  end

endmodule

/* sv/load_current_supervisor.sv */
// Top level of the load current supervisor: input register, state and result handshake.
//
// Input channel: a command beat (op_i, current_setpoint_i, temperature_i) is taken at a
// rising edge with in_valid_i high and in_stall_o low. op 0 regulates, 1 switches the
// load on, 2 switches it off; op 3 leaves the state alone and reports it.
// Output channel: one result beat per command, taken at an edge with out_valid_o high
// and out_stall_i low. It shows DAC code, DAC power, load-on, fault and fan state
// after that command.
// Configuration: cfg_valid_i with cfg_index_i/cfg_data_i writes one register; the port
// is always ready. Write only while no command is in flight.
// Pipeline: a taken beat is held in the input register, and its result in the state/result register.
// Throughput: one command per cycle while out_stall_i is low, set by the single
// multiply-and-saturate path between the input register and the state/result register.
// Reset: all flags clear, DAC code 0 and powered down, registers at their defaults,
// no beats held.
// Stall: a stalled result holds; one more command can wait in the input register,
// after which in_stall_o rises.
`timescale 1ns / 1ps

module load_current_supervisor import lcs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              op_i,
  input  logic signed [SetpW-1:0] current_setpoint_i,
  input  logic signed [TempW-1:0] temperature_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [DacW-1:0]         dac_code_o,
  output logic                    dac_powered_o,
  output logic                    load_on_o,
  output logic                    fault_flag_o,
  output logic                    fan_running_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i
);

  lcs_cfg_t   cfg;
  lcs_item_t  item_q;
  logic       item_valid_q, item_valid_d;
  lcs_state_t state_q, state_d;
  lcs_state_t step_next;
  logic       out_valid_q, out_valid_d;
  logic       advance;
  logic       in_take;

  lcs_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  lcs_step u_step (
    .cfg_i   (cfg),
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (step_next)
  );

  assign advance = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign in_take = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (!in_stall_o) begin
      item_valid_d = in_valid_i;
    end
    state_d = advance ? step_next : state_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      state_q <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q <= out_valid_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op <= op_i;
      item_q.setpoint <= current_setpoint_i;
      item_q.temp <= temperature_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dac_code_o = state_q.dac_value;
  assign dac_powered_o = state_q.dac_en;
  assign load_on_o = state_q.enabled;
  assign fault_flag_o = state_q.fault;
  assign fan_running_o = state_q.fan;

endmodule
